FILE: rtl/edpd_pkg.sv
package edpd_pkg;

   localparam int POINTER_BITS_DEFAULT  = 64;
   localparam int MAX_LEB_BYTES_DEFAULT = 10;
   localparam int QUEUE_DEPTH           = 2;

   // encoding byte fields
   localparam logic [7:0] ENC_OMIT     = 8'hFF;
   localparam logic [2:0] MODE_ABS     = 3'h0;
   localparam logic [2:0] MODE_PCREL   = 3'h1;
   localparam logic [3:0] FMT_ABSPTR   = 4'h0;
   localparam logic [3:0] FMT_ULEB128  = 4'h1;
   localparam logic [3:0] FMT_UDATA2   = 4'h2;
   localparam logic [3:0] FMT_UDATA4   = 4'h3;
   localparam logic [3:0] FMT_UDATA8   = 4'h4;
   localparam logic [3:0] FMT_SLEB128  = 4'h9;
   localparam logic [3:0] FMT_SDATA2   = 4'hA;
   localparam logic [3:0] FMT_SDATA4   = 4'hB;
   localparam logic [3:0] FMT_SDATA8   = 4'hC;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_FORMAT   = 2'd1,
      ERR_MODE     = 2'd2,
      ERR_OVERLONG = 2'd3
   } error_type;

   typedef enum logic [2:0] {
      KIND_OMIT       = 3'd0,
      KIND_BAD_FORMAT = 3'd1,
      KIND_BAD_MODE   = 3'd2,
      KIND_LEB        = 3'd3,
      KIND_FIXED      = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [7:0]  encoding;
      logic [63:0] field_address;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] pointer_value;
      logic        needs_indirect;
      logic        byte_consumed;
      logic [1:0]  error_code;
   } rsp_payload_type;

   // classified byte handed from the front to the back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [63:0] field_address;
      logic [3:0]  size;
      logic        is_signed;
      logic        relative;
      logic        indirect;
   } entry_type;

endpackage

FILE: rtl/edpd_chan_if.sv
interface edpd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/edpd_front.sv
module edpd_front #(
   parameter int POINTER_BITS = edpd_pkg::POINTER_BITS_DEFAULT
) (
   edpd_chan_if.sink          req_chan,
   output logic               push_valid,
   input  logic               push_ready,
   output edpd_pkg::entry_type push_entry
);
   import edpd_pkg::*;

   localparam logic [3:0] PTR_BYTES = 4'(POINTER_BITS / 8);

   logic [3:0] fmt;
   logic [2:0] mode;
   logic       fmt_ok;
   logic       is_leb;
   logic [3:0] size;

   assign fmt  = req_chan.payload.encoding[3:0];
   assign mode = req_chan.payload.encoding[6:4];

   always_comb begin
      fmt_ok = 1'b1;
      is_leb = 1'b0;
      size   = 4'd0;
      unique case (fmt)
         FMT_ABSPTR:               size = PTR_BYTES;
         FMT_ULEB128, FMT_SLEB128: is_leb = 1'b1;
         FMT_UDATA2, FMT_SDATA2:   size = 4'd2;
         FMT_UDATA4, FMT_SDATA4:   size = 4'd4;
         FMT_UDATA8, FMT_SDATA8:   size = 4'd8;
         default:                  fmt_ok = 1'b0;
      endcase
   end

   always_comb begin
      push_entry.data_byte     = req_chan.payload.data_byte;
      push_entry.field_address = req_chan.payload.field_address;
      push_entry.size          = size;
      push_entry.is_signed     = fmt[3];
      push_entry.relative      = (mode == MODE_PCREL);
      push_entry.indirect      = req_chan.payload.encoding[7];
      // format error wins over mode error
      priority if (req_chan.payload.encoding == ENC_OMIT) begin
         push_entry.kind = KIND_OMIT;
      end else if (!fmt_ok) begin
         push_entry.kind = KIND_BAD_FORMAT;
      end else if (mode != MODE_ABS && mode != MODE_PCREL) begin
         push_entry.kind = KIND_BAD_MODE;
      end else if (is_leb) begin
         push_entry.kind = KIND_LEB;
      end else begin
         push_entry.kind = KIND_FIXED;
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

FILE: rtl/edpd_queue.sv
module edpd_queue #(
   parameter int DEPTH = edpd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  edpd_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_pop,
   output edpd_pkg::entry_type out_entry
);
   import edpd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL  = CNT_W'(DEPTH);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != FULL);
   assign out_valid = (count_ff != '0);
   assign out_entry = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

FILE: rtl/edpd_back.sv
module edpd_back #(
   parameter int POINTER_BITS  = edpd_pkg::POINTER_BITS_DEFAULT,
   parameter int MAX_LEB_BYTES = edpd_pkg::MAX_LEB_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                entry_valid,
   input  edpd_pkg::entry_type entry,
   output logic                entry_pop,
   edpd_chan_if.source         rsp_chan
);
   import edpd_pkg::*;

   localparam logic [63:0] PTR_MASK  = {64{1'b1}} >> (64 - POINTER_BITS);
   localparam logic [3:0]  LEB_LIMIT = 4'(MAX_LEB_BYTES);

   // field state
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  shift_ff, shift_in;
   logic [3:0]  taken_ff, taken_in;
   logic        busy_ff, busy_in;
   logic [63:0] start_ff, start_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic        is_leb;
   logic [63:0] start_addr;
   logic [63:0] lane;
   logic [63:0] merged;
   logic [6:0]  shift_next;
   logic [3:0]  taken_next;
   logic [63:0] leb_val;
   logic [6:0]  size_bits;
   logic [5:0]  sign_idx;
   logic [63:0] keep_mask;
   logic        fix_sign;
   logic [63:0] fix_val;
   logic [63:0] val_m;
   logic [63:0] val_sum;
   logic [63:0] final_val;

   assign entry_pop = entry_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      is_leb     = (entry.kind == KIND_LEB);
      start_addr = busy_ff ? start_ff : entry.field_address;
      lane       = is_leb ? {57'd0, entry.data_byte[6:0]} : {56'd0, entry.data_byte};
      // bits landing past bit 63 are dropped
      merged     = shift_ff[6] ? acc_ff : (acc_ff | (lane << shift_ff[5:0]));
      shift_next = shift_ff + (is_leb ? 7'd7 : 7'd8);
      taken_next = taken_ff + 4'd1;

      leb_val = merged;
      if (entry.is_signed && entry.data_byte[6] && !shift_next[6]) begin
         leb_val = merged | ({64{1'b1}} << shift_next[5:0]);
      end

      size_bits = {entry.size, 3'b000};
      sign_idx  = size_bits[5:0] - 6'd1;
      keep_mask = size_bits[6] ? {64{1'b1}} : ~({64{1'b1}} << size_bits[5:0]);
      fix_sign  = entry.is_signed && !size_bits[6] && merged[sign_idx];
      fix_val   = (merged & keep_mask) | (fix_sign ? ~keep_mask : 64'd0);

      val_m     = (is_leb ? leb_val : fix_val) & PTR_MASK;
      val_sum   = val_m + start_addr;
      final_val = (entry.relative && val_m != 64'd0) ? (val_sum & PTR_MASK) : val_m;
   end

   always_comb begin
      acc_in       = acc_ff;
      shift_in     = shift_ff;
      taken_in     = taken_ff;
      busy_in      = busy_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      if (entry_pop) begin
         // default: field ends with a good result
         acc_in                = '0;
         shift_in              = '0;
         taken_in              = '0;
         busy_in               = 1'b0;
         rsp_valid_in          = 1'b1;
         rsp_in.pointer_value  = final_val;
         rsp_in.needs_indirect = (final_val != 64'd0) && entry.indirect;
         rsp_in.byte_consumed  = 1'b1;
         rsp_in.error_code     = ERR_NONE;
         unique case (entry.kind)
            KIND_OMIT: begin
               rsp_in.pointer_value  = '0;
               rsp_in.needs_indirect = 1'b0;
               rsp_in.byte_consumed  = 1'b0;
            end
            KIND_BAD_FORMAT: begin
               rsp_in.pointer_value  = '0;
               rsp_in.needs_indirect = 1'b0;
               rsp_in.error_code     = ERR_FORMAT;
            end
            KIND_BAD_MODE: begin
               rsp_in.pointer_value  = '0;
               rsp_in.needs_indirect = 1'b0;
               rsp_in.error_code     = ERR_MODE;
            end
            KIND_LEB: begin
               if (entry.data_byte[7]) begin
                  if (taken_next >= LEB_LIMIT) begin
                     rsp_in.pointer_value  = '0;
                     rsp_in.needs_indirect = 1'b0;
                     rsp_in.error_code     = ERR_OVERLONG;
                  end else begin
                     acc_in       = merged;
                     shift_in     = shift_next;
                     taken_in     = taken_next;
                     busy_in      = 1'b1;
                     start_in     = start_addr;
                     rsp_valid_in = 1'b0;
                  end
               end
            end
            KIND_FIXED: begin
               if (taken_next < entry.size) begin
                  acc_in       = merged;
                  shift_in     = shift_next;
                  taken_in     = taken_next;
                  busy_in      = 1'b1;
                  start_in     = start_addr;
                  rsp_valid_in = 1'b0;
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         shift_ff     <= '0;
         taken_ff     <= '0;
         busy_ff      <= 1'b0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         shift_ff     <= shift_in;
         taken_ff     <= taken_in;
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

FILE: rtl/dwarf_encoded_pointer_decoder.sv
// Decodes one exception-table encoded pointer from a byte stream.
// req_chan carries one table byte per transaction, with the encoding byte
// and the byte's own address; the address of a field's first byte is kept
// for pc-relative adds. rsp_chan carries at most one result per byte: the
// pointer, the indirect flag, whether the byte was used, and an error code.
// Bytes in the middle of a field give no result.
// Each byte passes the queue slot and then the back end's output register.
// Throughput: one byte per cycle unless the receiver stalls, set by the back
// end's combinational accumulate step (shift, merge, extend, relative add).
// The front end classifies each byte and writes it into a two-entry queue;
// req_chan.ready is low only while that queue is full.
// When the receiver stalls, the result holds in the output register while
// the queue keeps taking bytes until it fills.
// Reset (synchronous, active high) empties the queue, drops any field in
// progress and clears rsp_chan.valid.
module dwarf_encoded_pointer_decoder #(
   parameter int POINTER_BITS  = edpd_pkg::POINTER_BITS_DEFAULT,
   parameter int MAX_LEB_BYTES = edpd_pkg::MAX_LEB_BYTES_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   edpd_chan_if.sink   req_chan,
   edpd_chan_if.source rsp_chan
);
   import edpd_pkg::*;

   localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - POINTER_BITS);

   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      head_valid;
   logic      head_pop;
   entry_type head_entry;

   edpd_front #(
      .POINTER_BITS (POINTER_BITS)
   ) u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   edpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (head_valid),
      .out_pop   (head_pop),
      .out_entry (head_entry)
   );

   edpd_back #(
      .POINTER_BITS  (POINTER_BITS),
      .MAX_LEB_BYTES (MAX_LEB_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (head_valid),
      .entry       (head_entry),
      .entry_pop   (head_pop),
      .rsp_chan    (rsp_chan)
   );

   // omit answers carry nothing but the flag
   a_omit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.byte_consumed |->
         rsp_chan.payload.pointer_value == 64'd0 &&
         rsp_chan.payload.error_code == ERR_NONE)
      else $error("omit result carries a value or error");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.error_code != ERR_NONE |->
         rsp_chan.payload.pointer_value == 64'd0 && !rsp_chan.payload.needs_indirect)
      else $error("error result carries a value");

   a_indirect_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.needs_indirect |->
         rsp_chan.payload.pointer_value != 64'd0)
      else $error("indirect flag on a zero pointer");

   a_ptr_width: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.pointer_value & ~PTR_MASK) == 64'd0)
      else $error("pointer exceeds pointer width");

endmodule

FILE: tb/edpd_pointer_checker.sv
module edpd_pointer_checker #(
   parameter int POINTER_BITS  = edpd_pkg::POINTER_BITS_DEFAULT,
   parameter int MAX_LEB_BYTES = edpd_pkg::MAX_LEB_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  edpd_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  edpd_pkg::rsp_payload_type rsp_payload,
   output int                        mismatches,
   output int                        outstanding
);
   import edpd_pkg::*;

   localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - POINTER_BITS);
   localparam int REPORT_LIMIT = 10;

   // decoder state mirrored from the block
   logic [63:0] acc;
   logic [6:0]  shamt;
   logic [3:0]  nbytes;
   logic        active;
   logic [63:0] base_addr;

   rsp_payload_type expected_pointers[$];
   rsp_payload_type predicted;
   rsp_payload_type oldest;
   int              fail_count;

   function automatic void drop_field();
      acc    = '0;
      shamt  = '0;
      nbytes = '0;
      active = 1'b0;
   endfunction

   // Returns 1 when the byte completes a transaction on the result side.
   function automatic bit decode_byte(input req_payload_type r, output rsp_payload_type o);
      logic [3:0]  fmt;
      logic [2:0]  mode;
      int unsigned size;
      int unsigned bits;
      bit          leb;
      logic [63:0] val;
      o = '0;
      o.byte_consumed = 1'b1;
      if (r.encoding == ENC_OMIT) begin
         drop_field();
         o.byte_consumed = 1'b0;
         return 1'b1;
      end
      fmt  = r.encoding[3:0];
      mode = r.encoding[6:4];
      leb  = 1'b0;
      size = 0;
      case (fmt)
         FMT_ABSPTR:              size = POINTER_BITS / 8;
         FMT_ULEB128, FMT_SLEB128: leb = 1'b1;
         FMT_UDATA2, FMT_SDATA2:  size = 2;
         FMT_UDATA4, FMT_SDATA4:  size = 4;
         FMT_UDATA8, FMT_SDATA8:  size = 8;
         default: begin
            drop_field();
            o.error_code = ERR_FORMAT;
            return 1'b1;
         end
      endcase
      if (mode != MODE_ABS && mode != MODE_PCREL) begin
         drop_field();
         o.error_code = ERR_MODE;
         return 1'b1;
      end
      if (!active) begin
         drop_field();
         base_addr = r.field_address;
         active    = 1'b1;
      end
      if (leb) begin
         if (shamt < 64) acc |= 64'(r.data_byte[6:0]) << shamt;
         shamt  = shamt + 7'd7;
         nbytes = nbytes + 4'd1;
         if (r.data_byte[7]) begin
            if (nbytes >= MAX_LEB_BYTES) begin
               drop_field();
               o.error_code = ERR_OVERLONG;
               return 1'b1;
            end
            return 1'b0;
         end
         val = acc;
         if (fmt == FMT_SLEB128 && r.data_byte[6] && shamt < 64) val |= ~64'd0 << shamt;
      end else begin
         bits = size * 8;
         if (shamt < 64) acc |= 64'(r.data_byte) << shamt;
         shamt  = shamt + 7'd8;
         nbytes = nbytes + 4'd1;
         if (nbytes < size) return 1'b0;
         val = acc;
         if (bits < 64) begin
            val &= (64'd1 << bits) - 64'd1;
            if (fmt[3] && val[bits-1]) val |= ~64'd0 << bits;
         end
      end
      val &= PTR_MASK;
      if (mode == MODE_PCREL && val != 0) val = (val + base_addr) & PTR_MASK;
      drop_field();
      o.pointer_value  = val;
      o.needs_indirect = (val != 0) && r.encoding[7];
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         drop_field();
         base_addr = '0;
         expected_pointers.delete();
         fail_count = 0;
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (decode_byte(req_payload, predicted)) expected_pointers.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pointers.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected result: value %h ind %0b used %0b err %0d",
                           rsp_payload.pointer_value, rsp_payload.needs_indirect,
                           rsp_payload.byte_consumed, rsp_payload.error_code);
            end else begin
               oldest = expected_pointers.pop_front();
               if (rsp_payload.pointer_value !== oldest.pointer_value ||
                   rsp_payload.needs_indirect !== oldest.needs_indirect ||
                   rsp_payload.byte_consumed !== oldest.byte_consumed ||
                   rsp_payload.error_code !== oldest.error_code) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display({"mismatch: expected value %h ind %0b used %0b err %0d,",
                               " got value %h ind %0b used %0b err %0d"},
                              oldest.pointer_value, oldest.needs_indirect,
                              oldest.byte_consumed, oldest.error_code,
                              rsp_payload.pointer_value, rsp_payload.needs_indirect,
                              rsp_payload.byte_consumed, rsp_payload.error_code);
               end
            end
         end
         mismatches  <= fail_count;
         outstanding <= expected_pointers.size();
      end
   end

endmodule

FILE: tb/dwarf_encoded_pointer_decoder_tb.sv
module dwarf_encoded_pointer_decoder_tb;
   import edpd_pkg::*;

   localparam int ITEM_TARGET = 650;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 8;

   // encodings the block rejects
   localparam logic [3:0] FMT_RESERVED = 4'h5;
   localparam logic [2:0] MODE_TEXTREL = 3'h2;

   localparam logic [3:0] GOOD_FMTS [9] = '{FMT_ABSPTR, FMT_ULEB128, FMT_UDATA2, FMT_UDATA4,
                                            FMT_UDATA8, FMT_SLEB128, FMT_SDATA2, FMT_SDATA4,
                                            FMT_SDATA8};

   typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   burst_left = 0;
   int   sent = 0;

   edpd_chan_if #(.payload_type(req_payload_type)) req_chan ();
   edpd_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   dwarf_encoded_pointer_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   edpd_pointer_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] enc_of(input bit ind, input logic [2:0] mode,
                                         input logic [3:0] fmt);
      return {ind, mode, fmt};
   endfunction

   // one transaction on the request side; bursts of random length, random gaps
   task automatic send_byte(input logic [7:0] data, input logic [7:0] enc,
                            input logic [63:0] addr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{data_byte: data, encoding: enc, field_address: addr};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
      sent++;
   endtask

   task automatic send_field(input logic [7:0] enc, input logic [7:0] bytes[$],
                             input logic [63:0] addr);
      foreach (bytes[i]) send_byte(bytes[i], enc, addr + 64'(i));
   endtask

   // hold the sender off until every expected result has been taken
   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_address();
      case ($urandom_range(0, 9))
         0:       return ~64'd0 - 64'($urandom_range(0, 3));
         1:       return 64'($urandom_range(0, 15));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random field, at times an overlong LEB one; partial ones leave a field open
   task automatic send_random_field(input bit partial);
      logic [3:0]  fmt;
      logic [7:0]  enc;
      logic [7:0]  bytes[$];
      logic [7:0]  b;
      int          n;
      bit          leb;
      bit          overlong;
      bit          zero;
      fmt      = GOOD_FMTS[$urandom_range(0, 8)];
      enc      = enc_of(1'($urandom_range(0, 1)),
                        $urandom_range(0, 1) ? MODE_PCREL : MODE_ABS, fmt);
      leb      = 1'b0;
      overlong = 1'b0;
      case (fmt)
         FMT_ULEB128, FMT_SLEB128: begin
            leb      = 1'b1;
            overlong = ($urandom_range(0, 9) == 0);
            n        = overlong ? MAX_LEB_BYTES_DEFAULT : $urandom_range(1, 10);
         end
         FMT_UDATA2, FMT_SDATA2: n = 2;
         FMT_UDATA4, FMT_SDATA4: n = 4;
         default:                n = 8;
      endcase
      zero = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++) begin
         b = zero ? 8'h00 : 8'($urandom_range(0, 255));
         if (leb) b[7] = (i != n - 1) || overlong;
         bytes.push_back(b);
      end
      if (partial && n > 1) bytes = bytes[0:$urandom_range(0, n - 2)];
      send_field(enc, bytes, pick_address());
   endtask

   // receiver: ready follows a pattern that is chosen anew for each random span
   initial begin
      rx_pattern_type pattern;
      int             span;
      rsp_chan.ready <= 1'b0;
      forever begin
         pattern = rx_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(16, 200);
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            case (pattern)
               RX_FREE:   rsp_chan.ready <= 1'b1;
               RX_RANDOM: rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
               default:   rsp_chan.ready <= k[2];
            endcase
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle = 0;
         else
            idle++;
      end
      $display("dwarf_encoded_pointer_decoder_tb: errors");
      $finish;
   end

   initial begin
      logic [7:0] leb_run[$];
      int         roll;
      int         target;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_field(ENC_OMIT, '{8'h00}, 64'd0);
      // sign extension plus pc-relative add wrapping past the top of memory
      send_field(enc_of(1'b0, MODE_PCREL, FMT_SDATA2), '{8'h00, 8'h80}, ~64'd0);
      send_field(enc_of(1'b1, MODE_ABS, FMT_UDATA4), '{8'hFF, 8'hFF, 8'hFF, 8'hFF}, 64'd0);
      // zero pc-relative value stays zero
      send_field(enc_of(1'b1, MODE_PCREL, FMT_ULEB128), '{8'h00}, ~64'd0);
      send_field(enc_of(1'b1, MODE_PCREL, FMT_SLEB128), '{8'h40}, 64'h8000_0000_0000_0000);
      send_field(enc_of(1'b0, MODE_ABS, FMT_RESERVED), '{8'hFF}, 64'd0);
      send_field(enc_of(1'b1, MODE_TEXTREL, FMT_UDATA4), '{8'h7F}, 64'd0);
      send_field(enc_of(1'b0, MODE_TEXTREL, FMT_RESERVED), '{8'h01}, 64'd0);
      // continuation bit still set on the last allowed LEB byte
      repeat (MAX_LEB_BYTES_DEFAULT) leb_run.push_back(8'h80);
      send_field(enc_of(1'b0, MODE_ABS, FMT_ULEB128), leb_run, 64'h0123_4567_89AB_CDEF);
      // omit abandons a field in progress
      send_field(enc_of(1'b0, MODE_ABS, FMT_UDATA2), '{8'h55}, 64'd0);
      send_field(ENC_OMIT, '{8'hAA}, ~64'd0);
      drain();

      target = sent + ITEM_TARGET;
      while (sent < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            drain();
         else if (roll < 15)
            send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_address());
         else if (roll < 23)
            send_random_field(1'b1);
         else
            send_random_field(1'b0);
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("dwarf_encoded_pointer_decoder_tb: clean");
      else
         $display("dwarf_encoded_pointer_decoder_tb: errors");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/edpd_pkg.sv
rtl/edpd_chan_if.sv
rtl/edpd_front.sv
rtl/edpd_queue.sv
rtl/edpd_back.sv
rtl/dwarf_encoded_pointer_decoder.sv
tb/edpd_pointer_checker.sv
tb/dwarf_encoded_pointer_decoder_tb.sv
